// ===== rtl/core/kmp_pkg.sv =====
package kmp_pkg;

    // pattern capacity, one cell per pattern byte
    localparam int PATTERN_MAX = 1024;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

    // result fields and text position share one width
    localparam int FIELD_W     = 24;
    localparam int POS_W       = FIELD_W;

    // hit reduction: cells are OR-ed in groups, then the groups
    localparam int GROUP_SIZE  = 32;
    localparam int NGROUPS     = PATTERN_MAX / GROUP_SIZE;

    localparam int BYTE_W      = 8;

    // operation codes on the input side
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic              step;          // an item is accepted this cycle
        logic              is_text;       // text byte, otherwise pattern byte
        logic              clear_pattern; // pattern byte that opens a new pattern
        logic              clear_match;   // text byte that opens a new text
        logic [BYTE_W-1:0] data;          // pattern or text byte
    } cell_ctl_t;

endpackage

// ===== rtl/core/kmp_cell.sv =====
module kmp_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  kmp_pkg::cell_ctl_t ctl,
    input  logic              prev_valid,  // previous cell holds a byte (masked by clear)
    input  logic              prev_active, // prefix up to previous cell matched (masked)
    input  logic              next_valid,  // next cell holds a byte
    output logic              valid,
    output logic              active,
    output logic              hit
);
    import kmp_pkg::*;

    logic              valid_reg, valid_next;
    logic              active_reg, active_next;
    logic              hit_reg, hit_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              own_valid;
    logic              load;
    logic              is_last;
    logic              extend;

    // this cell is the end of the stored pattern
    assign is_last   = valid_reg & ~next_valid;
    // prefix ending here extends with the text byte
    assign extend    = valid_reg & prev_active & (byte_reg == ctl.data);

    // pattern append fills the first empty cell after the filled run
    assign own_valid = valid_reg & ~ctl.clear_pattern;
    assign load      = ctl.step & ~ctl.is_text & prev_valid & ~own_valid;

    always_comb
    begin
        valid_next  = valid_reg;
        active_next = active_reg;
        hit_next    = hit_reg;
        if (ctl.step)
        begin
            if (ctl.is_text)
            begin
                // full match is reported and dropped, as after a failure-link fallback
                active_next = extend & ~is_last;
                hit_next    = extend & is_last;
            end
            else
            begin
                valid_next  = own_valid | load;
                active_next = active_reg & ~ctl.clear_pattern;
                hit_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
            hit_reg    <= hit_next;
        end
    end

    // pattern byte, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= ctl.data;
        end
    end

    assign valid  = valid_reg;
    assign active = active_reg;
    assign hit    = hit_reg;

endmodule

// ===== rtl/core/kmp_hit_reduce.sv =====
module kmp_hit_reduce (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [kmp_pkg::PATTERN_MAX-1:0] hits,
    output logic                            any_hit
);
    import kmp_pkg::*;

    logic [NGROUPS-1:0] group_reg;
    logic [NGROUPS-1:0] group_next;

    // first level: one OR per group of cells
    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            group_next[g] = |hits[g*GROUP_SIZE +: GROUP_SIZE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
        end
        else if (advance)
        begin
            group_reg <= group_next;
        end
    end

    // second level over the registered groups
    assign any_hit = |group_reg;

endmodule

// ===== rtl/core/kmp_stream_matcher.sv =====
// Results pass the cell hit flags, group ORs and output register. Throughput: one item
// per cycle when not stalled; each pattern byte sits in its own cell and every cell
// compares the text byte at once, so no failure-link walk is needed.
// Input stalls only while a result is blocked by a full output register.
// Reset (rst_n low, asynchronous) empties the pattern and clears position and count.
module kmp_stream_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
    input  logic [1:0]  s_axis_tuser,  // [0] operation, [1] first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // [23:0] match_start, [47:24] match_count
);
    import kmp_pkg::*;

    logic                   accept;
    logic                   advance;
    logic                   op;
    logic                   first;
    cell_ctl_t              ctl;

    logic [PATTERN_MAX-1:0] cell_valid;
    logic [PATTERN_MAX-1:0] cell_active;
    logic [PATTERN_MAX-1:0] cell_hit;

    logic [LEN_W-1:0]       len_reg, len_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [POS_W-1:0]       pos_base;
    logic [FIELD_W-1:0]     start_next;

    // stage 0: item just applied to the cells
    logic                   s0_valid_reg;
    logic                   s0_text_reg;
    logic                   s0_clear_reg;
    logic [FIELD_W-1:0]     s0_start_reg;
    // stage 1: group ORs registered, result decided
    logic                   s1_valid_reg;
    logic                   s1_text_reg;
    logic                   s1_clear_reg;
    logic [FIELD_W-1:0]     s1_start_reg;
    logic                   any_hit;
    logic                   s1_hit;

    logic [FIELD_W-1:0]     count_reg, count_next;
    logic [FIELD_W-1:0]     count_base;

    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]     out_start_reg;
    logic [FIELD_W-1:0]     out_count_reg;

    assign op      = s_axis_tuser[0];
    assign first   = s_axis_tuser[1];

    // hold everything only while a result cannot be placed
    assign s1_hit        = s1_valid_reg & s1_text_reg & any_hit;
    assign advance       = ~(s1_hit & out_valid_reg & ~m_axis_tready);
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid & advance;

    // broadcast control
    always_comb
    begin
        ctl.step          = accept;
        ctl.is_text       = (op == OP_TEXT);
        ctl.clear_pattern = (op == OP_PATTERN) & first;
        ctl.clear_match   = (op == OP_TEXT) & first;
        ctl.data          = s_axis_tdata;
    end

    // row of cells, cell k holds pattern byte k
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic pv;
            logic pa;
            logic nv;
            if (k == 0)
            begin : g_head
                assign pv = 1'b1;
                assign pa = 1'b1;
            end
            else
            begin : g_body
                assign pv = cell_valid[k-1] & ~ctl.clear_pattern;
                assign pa = cell_active[k-1] & ~ctl.clear_match;
            end
            if (k == PATTERN_MAX - 1)
            begin : g_tail
                assign nv = 1'b0;
            end
            else
            begin : g_mid
                assign nv = cell_valid[k+1];
            end
            kmp_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .prev_valid  (pv),
                .prev_active (pa),
                .next_valid  (nv),
                .valid       (cell_valid[k]),
                .active      (cell_active[k]),
                .hit         (cell_hit[k])
            );
        end
    endgenerate

    kmp_hit_reduce u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .hits    (cell_hit),
        .any_hit (any_hit)
    );

    // pattern length and text position, updated at accept
    always_comb
    begin
        len_next   = len_reg;
        pos_next   = pos_reg;
        pos_base   = first ? '0 : pos_reg;
        start_next = FIELD_W'(1);
        if (op == OP_PATTERN)
        begin
            if (first)
            begin
                len_next = LEN_W'(1);
                pos_next = '0;
            end
            else if (len_reg != LEN_W'(PATTERN_MAX))
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end
        else
        begin
            pos_next = (pos_base == {POS_W{1'b1}}) ? pos_base : pos_base + POS_W'(1);
            if (pos_next >= POS_W'(len_reg))
            begin
                start_next = FIELD_W'(pos_next - POS_W'(len_reg) + POS_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            len_reg <= len_next;
            pos_reg <= pos_next;
        end
    end

    // item tags along the reduction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_text_reg  <= (op == OP_TEXT);
            s0_clear_reg <= first;
            s0_start_reg <= start_next;
            s1_text_reg  <= s0_text_reg;
            s1_clear_reg <= s0_clear_reg;
            s1_start_reg <= s0_start_reg;
        end
    end

    // match count, in item order
    always_comb
    begin
        count_base = s1_clear_reg ? '0 : count_reg;
        count_next = count_base;
        if (s1_hit && (count_base != {FIELD_W{1'b1}}))
        begin
            count_next = count_base + FIELD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (advance && s1_valid_reg)
        begin
            count_reg <= count_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg & ~m_axis_tready;
        if (advance && s1_hit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_hit)
        begin
            out_start_reg <= s1_start_reg;
            out_count_reg <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_start_reg};

    // only the last pattern cell can report a full match
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_hit))
        else $error("more than one cell reports a match");

    // filled cells agree with the pattern length
    a_len_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(len_reg))
        else $error("cell fill does not match pattern length");

    // a delivered result always carries a nonzero count
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg != '0))
        else $error("result with zero match count");

    // a pattern byte never produces a result
    a_pattern_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_text_reg) |-> !s1_hit)
        else $error("pattern item flagged as match");

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import kmp_pkg::*;

    localparam int IDX_W        = LEN_W - 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_LEN     = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] count;
    } match_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] byte_value
    logic [1:0]  s_axis_tuser = '0;   // [0] operation, [1] first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [23:0] match_start, [47:24] match_count

    // idle and stall rates in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    // matcher state mirrored on the bench side
    logic [7:0]         pat_bytes [PATTERN_MAX];
    logic [IDX_W-1:0]   pat_fail  [PATTERN_MAX];
    logic [LEN_W-1:0]   pat_len   = '0;
    logic [IDX_W-1:0]   build_len = '0;
    logic [IDX_W-1:0]   match_len = '0;
    logic [POS_W-1:0]   text_pos  = '0;
    logic [FIELD_W-1:0] hit_count = '0;

    match_t expected_matches [$];

    kmp_stream_matcher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 unit clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // walk failure links from prefix length k until byte b extends it
    function automatic logic [LEN_W-1:0] extend_prefix(input logic [LEN_W-1:0] k_in,
                                                      input logic [7:0] b);
        logic [LEN_W-1:0] k;
        k = k_in;
        while (k > 0 && k < PATTERN_MAX && pat_bytes[k] != b)
            k = LEN_W'(pat_fail[k - 1]);
        if (k < PATTERN_MAX && pat_bytes[k] == b)
            k = k + 1'b1;
        return k;
    endfunction

    // update mirrored state for one accepted item, queue any match it yields
    task automatic predict_match(input logic op, input logic [7:0] b, input logic first_flag);
        logic [LEN_W-1:0] j;
        logic [POS_W-1:0] start_pos;
        match_t           hit;
        if (op == OP_PATTERN)
        begin
            if (first_flag)
            begin
                pat_len   = '0;
                build_len = '0;
                match_len = '0;
                text_pos  = '0;
                hit_count = '0;
            end
            if (pat_len < PATTERN_MAX)
            begin
                pat_bytes[pat_len] = b;
                if (pat_len == 0)
                begin
                    pat_fail[0] = '0;
                    build_len   = '0;
                end
                else
                begin
                    j = extend_prefix(LEN_W'(build_len), b);
                    pat_fail[pat_len] = j[IDX_W-1:0];
                    build_len         = j[IDX_W-1:0];
                end
                pat_len = pat_len + 1'b1;
            end
        end
        else
        begin
            if (first_flag)
            begin
                text_pos  = '0;
                hit_count = '0;
                match_len = '0;
            end
            if (text_pos != '1)
                text_pos = text_pos + 1'b1;
            if (pat_len != 0)
            begin
                j = LEN_W'(match_len);
                if (j >= pat_len)
                    j = '0;
                j = extend_prefix(j, b);
                if (j != pat_len)
                    match_len = j[IDX_W-1:0];
                else
                begin
                    match_len = pat_fail[pat_len - 1];
                    if (hit_count != '1)
                        hit_count = hit_count + 1'b1;
                    start_pos = (text_pos >= pat_len) ? text_pos - pat_len + 1'b1 : POS_W'(1);
                    hit.start = start_pos;
                    hit.count = hit_count;
                    expected_matches.push_back(hit);
                end
            end
        end
    endtask

    // present one item, wait for the handshake, then predict
    task automatic send_item(input logic op, input logic [7:0] b, input logic first_flag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {first_flag, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_match(op, b, first_flag);
    endtask

    // empty pattern, overlaps, mid-text append, new text, single-byte pattern
    task automatic test_directed();
        send_item(OP_TEXT,    8'h55, 1'b1);   // no pattern yet: no match
        send_item(OP_TEXT,    8'hAA, 1'b0);
        send_item(OP_PATTERN, 8'hFF, 1'b1);
        send_item(OP_PATTERN, 8'h00, 1'b0);
        send_item(OP_PATTERN, 8'hFF, 1'b0);
        send_item(OP_TEXT,    8'hFF, 1'b1);
        send_item(OP_TEXT,    8'h00, 1'b0);
        send_item(OP_TEXT,    8'hFF, 1'b0);   // match at 1
        send_item(OP_TEXT,    8'h00, 1'b0);
        send_item(OP_TEXT,    8'hFF, 1'b0);   // overlapping match at 3
        send_item(OP_PATTERN, 8'h00, 1'b0);   // grow pattern, keep partial match
        send_item(OP_TEXT,    8'h00, 1'b0);
        send_item(OP_TEXT,    8'hFF, 1'b0);
        send_item(OP_TEXT,    8'h00, 1'b0);
        send_item(OP_TEXT,    8'h00, 1'b1);   // new text clears count
        send_item(OP_TEXT,    8'hFF, 1'b0);
        send_item(OP_TEXT,    8'h00, 1'b0);
        send_item(OP_TEXT,    8'hFF, 1'b0);
        send_item(OP_TEXT,    8'h00, 1'b0);
        send_item(OP_PATTERN, 8'h80, 1'b1);
        send_item(OP_TEXT,    8'h80, 1'b1);
        send_item(OP_TEXT,    8'h80, 1'b0);
        send_item(OP_TEXT,    8'h01, 1'b0);
        send_item(OP_TEXT,    8'h80, 1'b0);
    endtask

    // long repetitive pattern: back-to-back overlapping matches, deep fallback
    task automatic test_long_pattern();
        send_item(OP_PATTERN, 8'h61, 1'b1);
        repeat (LONG_LEN - 1)
            send_item(OP_PATTERN, 8'h61, 1'b0);
        send_item(OP_TEXT, 8'h61, 1'b1);
        repeat (LONG_LEN + 4)
            send_item(OP_TEXT, 8'h61, 1'b0);
        send_item(OP_TEXT, 8'h62, 1'b0);      // deep fallback to zero
        repeat (LONG_LEN)
            send_item(OP_TEXT, 8'h61, 1'b0);
        send_item(OP_PATTERN, 8'h61, 1'b1);   // new pattern after a long one
        send_item(OP_TEXT, 8'h61, 1'b0);
    endtask

    // mostly pattern/text runs over a small alphabet, plus noise and junk text
    task automatic test_random(input int n_items);
        int         sent;
        int         kind;
        int         pat_n;
        int         text_n;
        int         n_sym;
        logic [7:0] sym [3];
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(9);
            if (kind < 7)
            begin
                n_sym  = $urandom_range(2, 3);
                for (int i = 0; i < 3; i++)
                    sym[i] = 8'($urandom_range(255));
                pat_n  = $urandom_range(1, 5);
                text_n = $urandom_range(8, 30);
                for (int i = 0; i < pat_n; i++)
                    send_item(OP_PATTERN, sym[$urandom_range(n_sym - 1)], i == 0);
                for (int i = 0; i < text_n; i++)
                begin
                    if ($urandom_range(15) == 0)
                        send_item(OP_PATTERN, sym[$urandom_range(n_sym - 1)], 1'b0);
                    send_item(OP_TEXT, sym[$urandom_range(n_sym - 1)],
                              (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(31) == 0));
                end
                sent += pat_n + text_n;
            end
            else if (kind == 7)
            begin
                pat_n = $urandom_range(1, 10);
                repeat (pat_n)
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                sent += pat_n;
            end
            else
            begin
                text_n = $urandom_range(4, 16);
                repeat (text_n)
                    send_item(OP_TEXT, 8'($urandom_range(255)), $urandom_range(7) == 0);
                sent += text_n;
            end
        end
    endtask

    // compare each accepted result with the oldest expected match
    always @(posedge clk)
    begin : check_results
        match_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_matches.size() == 0)
            begin
                $error("unexpected result: match_start %0d match_count %0d",
                       m_axis_tdata[23:0], m_axis_tdata[47:24]);
                fail_count++;
            end
            else
            begin
                want = expected_matches.pop_front();
                if (m_axis_tdata[23:0] !== want.start)
                begin
                    $error("match_start: expected %0d, got %0d", want.start, m_axis_tdata[23:0]);
                    fail_count++;
                end
                if (m_axis_tdata[47:24] !== want.count)
                begin
                    $error("match_count: expected %0d, got %0d", want.count,
                           m_axis_tdata[47:24]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("** kmp_stream_matcher: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 22;
        recv_stall_pct = 78;
        test_directed();
        test_long_pattern();
        test_random(85);

        send_idle_pct  = 78;
        recv_stall_pct = 22;
        test_random(85);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(85);

        s_axis_tvalid <= 1'b0;
        while (expected_matches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("** kmp_stream_matcher: PASSED **");
        else
            $display("** kmp_stream_matcher: FAILED **");
        $finish;
    end

endmodule
